/* rtl/mme_pkg.sv */
// Shared constants for the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

    // Largest matrix dimension held in the element stores.
    localparam int MAX_DIM = 64;

    // Field widths of the request and result items.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 32;
    localparam int SIZE_W  = 7;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 16;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_BITS   = OP_W + 2 * IDX_W + VAL_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 * IDX_W + VAL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    // Sizes above the store dimension behave as the store dimension.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size);
        return (size > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size;
    endfunction

endpackage

/* rtl/matrix_multiply_engine_unit.sv */
// Matrix multiply engine top level: element stores, shared MAC unit and sequencer.
`timescale 1ns / 1ps
// A write request gives no result unless its index is out of range.
// A compute request runs until its result is loaded into the output register; the next
// request is taken once the result has left or is leaving the output register. The single
// multiplier and the one read port of each store set this pace. Reset (rst_n low,
// asynchronous) clears the sequencer, the accumulator and the output valid and sets all
// sizes to 64; the stores are not cleared.

module matrix_multiply_engine_unit
    import mme_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // operation, row_index, col_index, element_value, zero padding
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_row, out_col, product_value, zero padding
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // index_error
    output logic                  m_axis_tuser
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [SIZE_W-1:0] a_rows_reg;
    logic [SIZE_W-1:0] inner_len_reg;
    logic [SIZE_W-1:0] b_cols_reg;
    logic [SIZE_W-1:0] ar_eff;
    logic [SIZE_W-1:0] il_eff;
    logic [SIZE_W-1:0] bc_eff;

    logic [OP_W-1:0]  in_op;
    logic [IDX_W-1:0] in_row;
    logic [IDX_W-1:0] in_col;
    logic [VAL_W-1:0] in_val;
    logic             accept;
    logic             in_range;

    logic              state_reg;
    logic              state_next;
    logic [SIZE_W-1:0] k_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic              issue;
    logic              drained;
    logic              rd_vld_reg;
    logic              prod_vld_reg;

    logic [VAL_W-1:0]        a_mem [STORE_DEPTH];
    logic [VAL_W-1:0]        b_mem [STORE_DEPTH];
    logic                    a_we;
    logic                    b_we;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       a_raddr;
    logic [ADDR_W-1:0]       b_raddr;
    logic signed [VAL_W-1:0] a_rd_reg;
    logic signed [VAL_W-1:0] b_rd_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0]        acc_reg;

    logic             pos_ovf;
    logic             neg_ovf;
    logic [VAL_W-1:0] sat_val;
    logic             load_err;
    logic             load_done;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [IDX_W-1:0] out_row_reg;
    logic [IDX_W-1:0] out_col_reg;
    logic [VAL_W-1:0] out_val_reg;
    logic             out_err_reg;

    assign in_op  = s_axis_tdata[OP_W-1:0];
    assign in_row = s_axis_tdata[OP_W +: IDX_W];
    assign in_col = s_axis_tdata[OP_W+IDX_W +: IDX_W];
    assign in_val = s_axis_tdata[OP_W+2*IDX_W +: VAL_W];

    assign ar_eff = clamp_size(a_rows_reg);
    assign il_eff = clamp_size(inner_len_reg);
    assign bc_eff = clamp_size(b_cols_reg);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg    <= SIZE_RESET;
            inner_len_reg <= SIZE_RESET;
            b_cols_reg    <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_A_ROWS:    a_rows_reg    <= cfg_data;
                REG_INNER_LEN: inner_len_reg <= cfg_data;
                REG_B_COLS:    b_cols_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        case (in_op)
            OP_WRITE_A: in_range = ({1'b0, in_row} < ar_eff) && ({1'b0, in_col} < il_eff);
            OP_WRITE_B: in_range = ({1'b0, in_row} < il_eff) && ({1'b0, in_col} < bc_eff);
            OP_COMPUTE: in_range = ({1'b0, in_row} < ar_eff) && ({1'b0, in_col} < bc_eff);
            default:    in_range = 1'b1;
        endcase
    end

    // Element stores: written from idle, read one term per cycle while computing.
    assign a_we    = accept && (in_op == OP_WRITE_A) && in_range;
    assign b_we    = accept && (in_op == OP_WRITE_B) && in_range;
    assign wr_addr = {in_row, in_col};
    assign a_raddr = {row_reg, k_reg[IDX_W-1:0]};
    assign b_raddr = {k_reg[IDX_W-1:0], col_reg};

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[wr_addr] <= in_val;
        end
        a_rd_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[wr_addr] <= in_val;
        end
        b_rd_reg <= b_mem[b_raddr];
    end

    // Sequencer: issue one term a cycle, then wait for the read and multiply stages to empty.
    assign issue   = (state_reg == ST_RUN) && (k_reg < il_eff);
    assign drained = (state_reg == ST_RUN) && !issue && !rd_vld_reg && !prod_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_op == OP_COMPUTE) && in_range)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (state_reg == ST_IDLE)
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (accept && (in_op == OP_COMPUTE) && in_range)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
        end
        prod_reg <= ACC_W'(a_rd_reg * b_rd_reg);
    end

    // Q32.32 to Q16.16: the arithmetic shift keeps bits 47:16, bits 62:47 must match the sign bit.
    assign pos_ovf = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:FRAC_W+VAL_W-1]);
    assign neg_ovf = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:FRAC_W+VAL_W-1]);

    always_comb
    begin
        if (pos_ovf)
        begin
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            sat_val = acc_reg[FRAC_W +: VAL_W];
        end
    end

    // Output register.
    assign load_err  = accept && (in_op != OP_UNUSED) && !in_range;
    assign load_done = drained;

    always_comb
    begin
        if (load_err || load_done)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_err)
        begin
            out_row_reg <= in_row;
            out_col_reg <= in_col;
            out_val_reg <= '0;
            out_err_reg <= 1'b1;
        end
        else if (load_done)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            out_val_reg <= sat_val;
            out_err_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_val_reg, out_col_reg, out_row_reg};
    assign m_axis_tuser  = out_err_reg;

endmodule

/* rtl/mme_checker.sv */
// Port-level checks for the matrix multiply engine, bound to the top level.
`timescale 1ns / 1ps

module mme_checker
    import mme_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An index error always reports a zero product.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2*IDX_W +: VAL_W] == '0)
        else $error("index error with nonzero product");

    // The unused operation code never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[OP_W-1:0] == OP_UNUSED)
        && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
        else $error("result from unused operation");

    // Requests are only taken when the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("request taken over a pending result");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
